/* hdl/sapik_pkg.sv */
// ----------------------------------------------------------------------------
// sapik_pkg
// Shared constants, types and arithmetic steps for the sweeping-arm polar
// inverse kinematics pipeline (square root steps, CORDIC steps, arctan table).
// ----------------------------------------------------------------------------
package sapik_pkg;

    localparam int CORDIC_ITERATIONS = 28;
    localparam int SQRT_STEPS        = 32;
    localparam int CW                = 54;   // CORDIC x/y datapath width
    localparam int ZW                = 34;   // angle accumulator width
    localparam int NORM_TOP          = 49;   // normalize max(|x|,|y|) into [2^49, 2^50)

    localparam logic signed [ZW-1:0] PI_Q28     = 34'sd843314857;
    localparam logic signed [ZW-1:0] TWO_PI_Q28 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] SAT_MAX    = 34'sd2147483647;
    localparam logic signed [ZW-1:0] SAT_MIN    = -34'sd2147483648;

    // stepper roles
    localparam logic ROLE_ARM = 1'b0;
    localparam logic ROLE_BED = 1'b1;

    // configuration register indexes
    localparam logic CFG_LINK_LENGTH  = 1'b0;
    localparam logic CFG_STEPPER_ROLE = 1'b1;

    // data that rides along with each transaction
    typedef struct packed {
        logic               valid;
        logic               unreach;
        logic               r2_zero;
        logic signed [31:0] ref_angle;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_side;

    // one step of the restoring square root
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] res;
    } t_sqrt;

    // one CORDIC lane
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic        [CW-1:0] m;
        logic                 zero;
    } t_lane;

    function automatic logic signed [ZW-1:0] atan_q28(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 34'sd210828714;
            1:  v = 34'sd124459457;
            2:  v = 34'sd65760959;
            3:  v = 34'sd33381290;
            4:  v = 34'sd16755422;
            5:  v = 34'sd8385879;
            6:  v = 34'sd4193963;
            7:  v = 34'sd2097109;
            8:  v = 34'sd1048571;
            9:  v = 34'sd524287;
            10: v = 34'sd262144;
            11: v = 34'sd131072;
            12: v = 34'sd65536;
            13: v = 34'sd32768;
            14: v = 34'sd16384;
            15: v = 34'sd8192;
            16: v = 34'sd4096;
            17: v = 34'sd2048;
            18: v = 34'sd1024;
            19: v = 34'sd512;
            20: v = 34'sd256;
            21: v = 34'sd128;
            22: v = 34'sd64;
            23: v = 34'sd32;
            24: v = 34'sd16;
            25: v = 34'sd8;
            26: v = 34'sd4;
            27: v = 34'sd2;
            28: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // one result bit of the floor square root
    function automatic t_sqrt sqrt_step(input t_sqrt s, input int k);
        logic [63:0] sq_bit;
        logic [63:0] trial;
        t_sqrt       o;
        sq_bit = 64'd1 << (62 - 2 * k);
        trial  = s.res + sq_bit;
        if (s.rem >= trial) begin
            o.rem = s.rem - trial;
            o.res = (s.res >> 1) + sq_bit;
        end else begin
            o.rem = s.rem;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // fold into the right half plane and find the larger magnitude
    function automatic t_lane lane_prep(input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y);
        t_lane                l;
        logic        [CW-1:0] ay;
        l.zero = (x == '0) && (y == '0);
        l.z    = '0;
        l.x    = x;
        l.y    = y;
        if (x < 0) begin
            l.z = (y >= 0) ? PI_Q28 : -PI_Q28;
            l.x = -x;
            l.y = -y;
        end
        ay  = (l.y < 0) ? CW'(-l.y) : CW'(l.y);
        l.m = (CW'(l.x) > ay) ? CW'(l.x) : ay;
        return l;
    endfunction

    // shift left by k when the magnitude still has room
    function automatic t_lane norm_step(input t_lane l, input int k);
        t_lane       o;
        logic [CW-1:0] lim;
        o   = l;
        lim = CW'(1) << (NORM_TOP + 1 - k);
        if (l.m < lim) begin
            o.x = l.x <<< k;
            o.y = l.y <<< k;
            o.m = l.m << k;
        end
        return o;
    endfunction

    // one vectoring rotation
    function automatic t_lane cordic_step(input t_lane l, input int i);
        t_lane                o;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        o  = l;
        xs = l.x >>> i;
        ys = l.y >>> i;
        if (l.y >= 0) begin
            o.x = l.x + ys;
            o.y = l.y - xs;
            o.z = l.z + atan_q28(i);
        end else begin
            o.x = l.x - ys;
            o.y = l.y + xs;
            o.z = l.z - atan_q28(i);
        end
        return o;
    endfunction

endpackage

/* hdl/sweeping_arm_polar_inverse_kinematics.sv */
// ----------------------------------------------------------------------------
// sweeping_arm_polar_inverse_kinematics
// Stepper angle for a two-equal-link arm over a rotating bed: arm joint angle
// or unwrapped bed angle, per toolhead x,y, through square root and CORDIC
// pipelines.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     i_valid / o_stall    i_x_pos, i_y_pos, i_reference_angle
//  output    o_valid / i_stall    o_angle, o_normalized_reference, o_unreachable
//  config    i_cfg_wr_en          i_cfg_addr, i_cfg_wdata
//
//  One transaction enters per cycle unless the output is stalled. A result
//  passes 2 multiply/add stages, 33 square root stages, 3 CORDIC setup
//  stages, 28 CORDIC rotations, 3 finishing stages with the output register.
//  A stalled output freezes the whole pipeline; a one-entry skid register on
//  the input takes the transaction that arrives in that cycle, so o_stall is
//  a register. Reset is synchronous and clears all valid bits.
// ----------------------------------------------------------------------------
module sweeping_arm_polar_inverse_kinematics (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_addr,
    input  logic [30:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_x_pos,
    input  logic signed [31:0] i_y_pos,
    input  logic signed [31:0] i_reference_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_angle,
    output logic signed [31:0] o_normalized_reference,
    output logic               o_unreachable
);

    localparam int NC = sapik_pkg::CORDIC_ITERATIONS;
    localparam int NS = sapik_pkg::SQRT_STEPS;
    localparam int CW = sapik_pkg::CW;
    localparam int ZW = sapik_pkg::ZW;

    logic [30:0] r_link;
    logic        r_role;
    logic        en;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= 31'd6553600;
            r_role <= sapik_pkg::ROLE_ARM;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                sapik_pkg::CFG_LINK_LENGTH:  r_link <= i_cfg_wdata;
                sapik_pkg::CFG_STEPPER_ROLE: r_role <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic               r_out_valid;
    assign en = !(r_out_valid && i_stall);

    // input skid register: hold a transaction that arrives while frozen
    logic               r_skid_valid;
    logic signed [31:0] r_skid_x, r_skid_y, r_skid_ref;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (en) begin
            r_skid_valid <= 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!en && i_valid && !r_skid_valid) begin
            r_skid_x   <= i_x_pos;
            r_skid_y   <= i_y_pos;
            r_skid_ref <= i_reference_angle;
        end
    end
    assign o_stall = r_skid_valid;

    logic               src_valid;
    logic signed [31:0] src_x, src_y, src_ref;
    logic [31:0]        ax, ay;
    assign src_valid = r_skid_valid || i_valid;
    assign src_x     = r_skid_valid ? r_skid_x   : i_x_pos;
    assign src_y     = r_skid_valid ? r_skid_y   : i_y_pos;
    assign src_ref   = r_skid_valid ? r_skid_ref : i_reference_angle;
    assign ax        = src_x[31] ? (~src_x + 32'd1) : src_x;
    assign ay        = src_y[31] ? (~src_y + 32'd1) : src_y;

    // stage 1: squares
    sapik_pkg::t_side r_s1_side;
    logic [63:0]      r_s1_ax2, r_s1_ay2;
    logic [61:0]      r_s1_dd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_side.valid <= 1'b0;
        end else if (en) begin
            r_s1_side.valid     <= src_valid;
            r_s1_side.unreach   <= 1'b0;
            r_s1_side.r2_zero   <= 1'b0;
            r_s1_side.ref_angle <= src_ref;
            r_s1_side.x         <= src_x;
            r_s1_side.y         <= src_y;
            r_s1_ax2            <= ax * ax;
            r_s1_ay2            <= ay * ay;
            r_s1_dd             <= r_link * r_link;
        end
    end

    // stage 2: r^2, 4d^2 and reach test
    sapik_pkg::t_side r_s2_side;
    sapik_pkg::t_side n_s2_side;
    logic [63:0]      r_s2_r2, r_s2_fd2;
    logic [63:0]      s1_r2, s1_fd2;
    assign s1_r2  = r_s1_ax2 + r_s1_ay2;
    assign s1_fd2 = {r_s1_dd, 2'b00};
    always_comb begin
        n_s2_side         = r_s1_side;
        n_s2_side.unreach = (r_s1_dd == '0) || (s1_r2 > s1_fd2);
        n_s2_side.r2_zero = (s1_r2 == '0);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_side.valid <= 1'b0;
        end else if (en) begin
            r_s2_side <= n_s2_side;
            r_s2_r2   <= s1_r2;
            r_s2_fd2  <= s1_fd2;
        end
    end

    // square root pipeline: r = sqrt(r^2), s = sqrt(4d^2 - r^2)
    sapik_pkg::t_side r_sq_side [NS+1];
    sapik_pkg::t_sqrt r_sq_r    [NS+1];
    sapik_pkg::t_sqrt r_sq_s    [NS+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_side[0].valid <= 1'b0;
        end else if (en) begin
            r_sq_side[0]   <= r_s2_side;
            r_sq_r[0].rem  <= r_s2_r2;
            r_sq_r[0].res  <= '0;
            r_sq_s[0].rem  <= r_s2_side.unreach ? 64'd0 : (r_s2_fd2 - r_s2_r2);
            r_sq_s[0].res  <= '0;
        end
    end
    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_side[k+1].valid <= 1'b0;
            end else if (en) begin
                r_sq_side[k+1] <= r_sq_side[k];
                r_sq_r[k+1]    <= sapik_pkg::sqrt_step(r_sq_r[k], k);
                r_sq_s[k+1]    <= sapik_pkg::sqrt_step(r_sq_s[k], k);
            end
        end
    end

    // CORDIC setup: fold, then normalize in two halves
    sapik_pkg::t_side r_p1_side, r_p2_side;
    sapik_pkg::t_lane r_p1_h, r_p1_b, r_p2_h, r_p2_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_side.valid <= 1'b0;
            r_p2_side.valid <= 1'b0;
        end else if (en) begin
            r_p1_side <= r_sq_side[NS];
            r_p1_h    <= sapik_pkg::lane_prep(
                             CW'({1'b0, r_sq_r[NS].res[32:0]}),
                             CW'({1'b0, r_sq_s[NS].res[32:0]}));
            r_p1_b    <= sapik_pkg::lane_prep(CW'(r_sq_side[NS].x),
                                              CW'(r_sq_side[NS].y));
            r_p2_side <= r_p1_side;
            r_p2_h    <= sapik_pkg::norm_step(sapik_pkg::norm_step(
                             sapik_pkg::norm_step(r_p1_h, 32), 16), 8);
            r_p2_b    <= sapik_pkg::norm_step(sapik_pkg::norm_step(
                             sapik_pkg::norm_step(r_p1_b, 32), 16), 8);
        end
    end

    // CORDIC rotations, half-angle lane and bed lane side by side
    sapik_pkg::t_side r_c_side [NC+1];
    sapik_pkg::t_lane r_c_h    [NC+1];
    sapik_pkg::t_lane r_c_b    [NC+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side[0].valid <= 1'b0;
        end else if (en) begin
            r_c_side[0] <= r_p2_side;
            r_c_h[0]    <= sapik_pkg::norm_step(sapik_pkg::norm_step(
                               sapik_pkg::norm_step(r_p2_h, 4), 2), 1);
            r_c_b[0]    <= sapik_pkg::norm_step(sapik_pkg::norm_step(
                               sapik_pkg::norm_step(r_p2_b, 4), 2), 1);
        end
    end
    for (genvar i = 0; i < NC; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_side[i+1].valid <= 1'b0;
            end else if (en) begin
                r_c_side[i+1] <= r_c_side[i];
                r_c_h[i+1]    <= sapik_pkg::cordic_step(r_c_h[i], i);
                r_c_b[i+1]    <= sapik_pkg::cordic_step(r_c_b[i], i);
            end
        end
    end

    // finish 1: arm angle and raw bed angle
    sapik_pkg::t_side     r_f1_side;
    logic signed [ZW-1:0] r_f1_a0, r_f1_a1;
    logic signed [ZW-1:0] c_half, c_atb;
    assign c_half = (r_c_side[NC].unreach || r_c_h[NC].zero) ? '0 : r_c_h[NC].z;
    assign c_atb  = r_c_b[NC].zero ? '0 : r_c_b[NC].z;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_side.valid <= 1'b0;
        end else if (en) begin
            r_f1_side <= r_c_side[NC];
            r_f1_a0   <= c_half <<< 1;
            r_f1_a1   <= c_atb - (r_c_side[NC].r2_zero ? '0 : c_half);
        end
    end

    // finish 2: compare against the reference
    sapik_pkg::t_side     r_f2_side;
    logic signed [ZW-1:0] r_f2_angle;
    logic                 r_f2_up, r_f2_dn;
    logic signed [ZW-1:0] f1_diff;
    assign f1_diff = r_f1_a1 - ZW'(r_f1_side.ref_angle);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_side.valid <= 1'b0;
        end else if (en) begin
            r_f2_side  <= r_f1_side;
            r_f2_angle <= (r_role == sapik_pkg::ROLE_BED) ? r_f1_a1 : r_f1_a0;
            r_f2_up    <= (r_role == sapik_pkg::ROLE_BED) && (f1_diff < -sapik_pkg::PI_Q28);
            r_f2_dn    <= (r_role == sapik_pkg::ROLE_BED) && (f1_diff > sapik_pkg::PI_Q28);
        end
    end

    // output register: unwrap, saturate, normalize the reference
    logic signed [ZW-1:0] f2_adj, f2_ref, f2_nref;
    logic signed [31:0]   r_out_angle, r_out_nref;
    logic                 r_out_unreach;
    always_comb begin
        f2_adj = r_f2_angle;
        if (r_f2_up) begin
            f2_adj = r_f2_angle + sapik_pkg::TWO_PI_Q28;
        end else if (r_f2_dn) begin
            f2_adj = r_f2_angle - sapik_pkg::TWO_PI_Q28;
        end
        f2_ref  = ZW'(r_f2_side.ref_angle);
        f2_nref = f2_ref;
        if (f2_ref < -sapik_pkg::PI_Q28) begin
            f2_nref = f2_ref + sapik_pkg::TWO_PI_Q28;
        end else if (f2_ref > sapik_pkg::PI_Q28) begin
            f2_nref = f2_ref - sapik_pkg::TWO_PI_Q28;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid   <= r_f2_side.valid;
            r_out_unreach <= r_f2_side.unreach;
            r_out_nref    <= f2_nref[31:0];
            if (f2_adj > sapik_pkg::SAT_MAX) begin
                r_out_angle <= sapik_pkg::SAT_MAX[31:0];
            end else if (f2_adj < sapik_pkg::SAT_MIN) begin
                r_out_angle <= sapik_pkg::SAT_MIN[31:0];
            end else begin
                r_out_angle <= f2_adj[31:0];
            end
        end
    end

    assign o_valid                = r_out_valid;
    assign o_angle                = r_out_angle;
    assign o_normalized_reference = r_out_nref;
    assign o_unreachable          = r_out_unreach;

    // an unreachable arm target folds the joint straight
    a_unreach_arm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_unreach && (r_role == sapik_pkg::ROLE_ARM)
        |-> r_out_angle == 32'sd0)
        else $error("arm angle not zero for unreachable target");

    // normalized reference always lands within pi
    a_nref_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (ZW'(r_out_nref) >= -sapik_pkg::PI_Q28) &&
                        (ZW'(r_out_nref) <= sapik_pkg::PI_Q28))
        else $error("normalized reference out of range");

    // a parked transaction survives a frozen pipeline
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !en |=> r_skid_valid)
        else $error("skid transaction lost");

    // the last stage reaches the output register when the pipe advances
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_f2_side.valid |=> r_out_valid)
        else $error("transaction dropped before output");

endmodule
